// ----- rtl/core/dnsqp_pkg.sv -----
// dnsqp_pkg: types, constants and result record for the dns query parser
// no dependencies; used by rtl/core/dns_query_parser.sv
package dnsqp_pkg;

    localparam int MAX_NAME_CHARS = 255;
    localparam int HDR_BYTES      = 12;
    localparam int TAIL_BYTES     = 4;
    localparam int OUT_DEPTH      = 4;

    localparam int HDR_IDX_W  = $clog2(HDR_BYTES + 1);
    localparam int TAIL_IDX_W = $clog2(TAIL_BYTES + 1);
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    localparam logic [7:0] DOT_CHAR  = 8'h2e;
    localparam logic [7:0] NAME_MAX8 = 8'(MAX_NAME_CHARS);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN,
        PH_BODY,
        PH_TAIL,
        PH_DISCARD
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT_HDR   = 3'd1,
        ST_NO_QUESTION = 3'd2,
        ST_LBL_OVERRUN = 3'd3,
        ST_NO_TYPE     = 3'd4
    } status_t;

    typedef enum logic {
        KIND_CHAR    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    // one result item, fields from the highest bit down; kind goes on tuser, the rest in tdata order
    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [7:0]  name_length;
        logic [15:0] query_class;
        logic [15:0] query_type;
        logic [15:0] additional_count;
        logic [15:0] authority_count;
        logic [15:0] answer_count;
        logic [15:0] question_count;
        logic [15:0] hdr_flags;
        logic [15:0] txn_id;
        logic [7:0]  name_char;
    } result_t;

endpackage

// ----- rtl/core/dns_query_parser.sv -----
// dns_query_parser: byte-per-cycle parser for a dns query header and first question
// depends on dnsqp_pkg (rtl/core/dnsqp_pkg.sv)
//
//  channel | dir | ports                      | request
//  --------+-----+----------------------------+----------------------------------------
//  s_      | in  | tvalid tready tdata tlast  | one packet byte, tlast on the final byte
//  m_      | out | tvalid tready tdata tuser  | name character or packet summary
//
// one byte is taken per cycle while s_tready is high; the parse state updates in the
// cycle the byte is taken; each byte yields zero, one or two results, queued in a
// four-entry output buffer; s_tready is high while the buffer has room for two results,
// so a final byte that also carries a name character still fits with its summary
// results are registered in the output buffer; m_tready low only backs up into s_tready
// aresetn (synchronous) returns the parser to the header phase and empties the buffer
module dns_query_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] pkt_byte
    input  logic         s_tlast,   // end_of_packet
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // name_char, txn_id, hdr_flags, question_count,
                                    // answer_count, authority_count, additional_count,
                                    // query_type, query_class, name_length, status, zero pad
    output logic [0:0]   m_tuser    // [0] kind
);

    dnsqp_pkg::phase_t                        phase_reg, phase_next;
    logic [dnsqp_pkg::HDR_IDX_W-1:0]          hdr_idx_reg, hdr_idx_next;
    logic [7:0]                               hdr_byte_reg [dnsqp_pkg::HDR_BYTES];
    logic [7:0]                               hdr_byte_next [dnsqp_pkg::HDR_BYTES];
    logic [7:0]                               lbl_left_reg, lbl_left_next;
    logic [7:0]                               kept_len_reg, kept_len_next;
    logic [dnsqp_pkg::TAIL_IDX_W-1:0]         tail_idx_reg, tail_idx_next;
    logic [7:0]                               tail_byte_reg [dnsqp_pkg::TAIL_BYTES];
    logic [7:0]                               tail_byte_next [dnsqp_pkg::TAIL_BYTES];
    dnsqp_pkg::status_t                       err_reg, err_next;

    dnsqp_pkg::result_t                       out_mem [dnsqp_pkg::OUT_DEPTH];
    logic [dnsqp_pkg::OUT_PTR_W-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [dnsqp_pkg::OUT_CNT_W-1:0]          out_cnt_reg, out_cnt_next;

    logic               s_acc;
    logic               m_acc;
    logic               char_emit;
    logic [7:0]         char_val;
    dnsqp_pkg::status_t st;
    dnsqp_pkg::result_t char_res, sum_res, res0, res1;
    logic [1:0]         push_cnt;
    logic [7:0]         lbl_dec;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = (out_cnt_reg <= dnsqp_pkg::OUT_CNT_W'(dnsqp_pkg::OUT_DEPTH - 2));
    assign lbl_dec  = (lbl_left_reg != 8'd0) ? lbl_left_reg - 8'd1 : 8'd0;

    // parse state machine, next state from the byte being taken
    always_comb begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        hdr_byte_next = hdr_byte_reg;
        lbl_left_next = lbl_left_reg;
        kept_len_next = kept_len_reg;
        tail_idx_next = tail_idx_reg;
        tail_byte_next = tail_byte_reg;
        err_next      = err_reg;
        char_emit     = 1'b0;
        char_val      = s_tdata;
        st            = dnsqp_pkg::ST_OK;

        unique case (phase_reg)
            dnsqp_pkg::PH_HEADER: begin
                hdr_byte_next[hdr_idx_reg] = s_tdata;
                hdr_idx_next = hdr_idx_reg + dnsqp_pkg::HDR_IDX_W'(1);
                if (hdr_idx_next == dnsqp_pkg::HDR_IDX_W'(dnsqp_pkg::HDR_BYTES)) begin
                    if (hdr_byte_next[4] == 8'd0 && hdr_byte_next[5] == 8'd0) begin
                        err_next   = dnsqp_pkg::ST_NO_QUESTION;
                        phase_next = dnsqp_pkg::PH_DISCARD;
                        st         = dnsqp_pkg::ST_NO_QUESTION;
                    end else begin
                        phase_next = dnsqp_pkg::PH_LEN;
                        st         = dnsqp_pkg::ST_NO_TYPE;
                    end
                end else begin
                    st = dnsqp_pkg::ST_SHORT_HDR;
                end
            end
            dnsqp_pkg::PH_LEN: begin
                if (s_tdata == 8'd0) begin
                    phase_next = dnsqp_pkg::PH_TAIL;
                    st         = dnsqp_pkg::ST_NO_TYPE;
                end else if (s_tlast) begin
                    st = dnsqp_pkg::ST_LBL_OVERRUN;
                end else begin
                    // separator only between labels and while under the limit
                    if (kept_len_reg != 8'd0 && kept_len_reg < dnsqp_pkg::NAME_MAX8) begin
                        char_emit     = 1'b1;
                        char_val      = dnsqp_pkg::DOT_CHAR;
                        kept_len_next = kept_len_reg + 8'd1;
                    end
                    lbl_left_next = s_tdata;
                    phase_next    = dnsqp_pkg::PH_BODY;
                end
            end
            dnsqp_pkg::PH_BODY: begin
                if (kept_len_reg < dnsqp_pkg::NAME_MAX8) begin
                    char_emit     = 1'b1;
                    kept_len_next = kept_len_reg + 8'd1;
                end
                lbl_left_next = lbl_dec;
                if (lbl_dec == 8'd0) begin
                    phase_next = dnsqp_pkg::PH_LEN;
                    st         = dnsqp_pkg::ST_NO_TYPE;
                end else begin
                    st = dnsqp_pkg::ST_LBL_OVERRUN;
                end
            end
            dnsqp_pkg::PH_TAIL: begin
                tail_byte_next[tail_idx_reg[1:0]] = s_tdata;
                tail_idx_next = tail_idx_reg + dnsqp_pkg::TAIL_IDX_W'(1);
                if (tail_idx_next == dnsqp_pkg::TAIL_IDX_W'(dnsqp_pkg::TAIL_BYTES)) begin
                    phase_next = dnsqp_pkg::PH_DISCARD;
                    st         = dnsqp_pkg::ST_OK;
                end else begin
                    st = dnsqp_pkg::ST_NO_TYPE;
                end
            end
            dnsqp_pkg::PH_DISCARD: begin
                st = err_reg;
            end
            default: begin
                st = err_reg;
            end
        endcase
    end

    // result records built from the updated state
    always_comb begin
        char_res           = '0;
        char_res.kind      = dnsqp_pkg::KIND_CHAR;
        char_res.status    = dnsqp_pkg::ST_OK;
        char_res.name_char = char_val;

        sum_res                  = '0;
        sum_res.kind             = dnsqp_pkg::KIND_SUMMARY;
        sum_res.txn_id           = {hdr_byte_next[0],  hdr_byte_next[1]};
        sum_res.hdr_flags        = {hdr_byte_next[2],  hdr_byte_next[3]};
        sum_res.question_count   = {hdr_byte_next[4],  hdr_byte_next[5]};
        sum_res.answer_count     = {hdr_byte_next[6],  hdr_byte_next[7]};
        sum_res.authority_count  = {hdr_byte_next[8],  hdr_byte_next[9]};
        sum_res.additional_count = {hdr_byte_next[10], hdr_byte_next[11]};
        sum_res.query_type       = {tail_byte_next[0], tail_byte_next[1]};
        sum_res.query_class      = {tail_byte_next[2], tail_byte_next[3]};
        sum_res.name_length      = kept_len_next;
        sum_res.status           = st;

        res0     = char_emit ? char_res : sum_res;
        res1     = sum_res;
        push_cnt = s_acc ? (2'(char_emit) + 2'(s_tlast)) : 2'd0;
    end

    always_comb begin
        out_cnt_next = out_cnt_reg + dnsqp_pkg::OUT_CNT_W'(push_cnt)
                       - dnsqp_pkg::OUT_CNT_W'(m_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= dnsqp_pkg::PH_HEADER;
            hdr_idx_reg  <= '0;
            lbl_left_reg <= '0;
            kept_len_reg <= '0;
            tail_idx_reg <= '0;
            err_reg      <= dnsqp_pkg::ST_OK;
            for (int i = 0; i < dnsqp_pkg::HDR_BYTES; i++) begin
                hdr_byte_reg[i] <= '0;
            end
            for (int i = 0; i < dnsqp_pkg::TAIL_BYTES; i++) begin
                tail_byte_reg[i] <= '0;
            end
        end else if (s_acc) begin
            if (s_tlast) begin
                // packet done: back to the reset state for the next one
                phase_reg    <= dnsqp_pkg::PH_HEADER;
                hdr_idx_reg  <= '0;
                lbl_left_reg <= '0;
                kept_len_reg <= '0;
                tail_idx_reg <= '0;
                err_reg      <= dnsqp_pkg::ST_OK;
                for (int i = 0; i < dnsqp_pkg::HDR_BYTES; i++) begin
                    hdr_byte_reg[i] <= '0;
                end
                for (int i = 0; i < dnsqp_pkg::TAIL_BYTES; i++) begin
                    tail_byte_reg[i] <= '0;
                end
            end else begin
                phase_reg     <= phase_next;
                hdr_idx_reg   <= hdr_idx_next;
                lbl_left_reg  <= lbl_left_next;
                kept_len_reg  <= kept_len_next;
                tail_idx_reg  <= tail_idx_next;
                err_reg       <= err_next;
                hdr_byte_reg  <= hdr_byte_next;
                tail_byte_reg <= tail_byte_next;
            end
        end
    end

    // output buffer
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            out_mem[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2) begin
            out_mem[wr_ptr_reg + dnsqp_pkg::OUT_PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            out_cnt_reg <= '0;
        end else begin
            wr_ptr_reg  <= wr_ptr_reg + dnsqp_pkg::OUT_PTR_W'(push_cnt);
            rd_ptr_reg  <= rd_ptr_reg + dnsqp_pkg::OUT_PTR_W'(m_acc);
            out_cnt_reg <= out_cnt_next;
        end
    end

    assign m_tvalid   = (out_cnt_reg != '0);
    assign m_tdata    = {5'd0, out_mem[rd_ptr_reg][146:0]};
    assign m_tuser[0] = out_mem[rd_ptr_reg].kind;

    // checks
    a_buf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg <= dnsqp_pkg::OUT_CNT_W'(dnsqp_pkg::OUT_DEPTH))
        else $error("output buffer overflow");

    a_pair_ends_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt == 2'd2) |-> (res0.kind == dnsqp_pkg::KIND_CHAR
                                && res1.kind == dnsqp_pkg::KIND_SUMMARY))
        else $error("two results pushed without character then summary");

    a_pkt_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (phase_reg == dnsqp_pkg::PH_HEADER
                                && hdr_idx_reg == '0 && kept_len_reg == 8'd0))
        else $error("parser not back in header phase after final byte");

    a_body_owes_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == dnsqp_pkg::PH_BODY) |-> (lbl_left_reg != 8'd0))
        else $error("label body phase with no bytes owed");

    a_len_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !s_tlast) |=> (kept_len_reg >= $past(kept_len_reg)))
        else $error("kept name length went down inside a packet");

endmodule

// ----- tb/sv/dns_query_parser_test.sv -----
// dns_query_parser_test: self-checking bench for the dns query parser, packet bytes in,
// name characters and summary records out, checked against an in-bench parse of each byte
// depends on dnsqp_pkg and dns_query_parser (rtl/core)
`timescale 1ns / 100ps

module dns_query_parser_test;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wire_byte_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [7:0]   s_tdata  = '0;
    logic         s_tlast  = 1'b0;
    logic         m_tready = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [151:0] m_tdata;
    logic [0:0]   m_tuser;

    wire_byte_t           byte_stream[$];
    logic [7:0]           pkt_bytes[$];
    dnsqp_pkg::result_t   parsed_records[$];
    int                   n_items    = 0;
    int                   n_taken    = 0;
    int                   mismatches = 0;

    // parse state kept alongside the block
    dnsqp_pkg::phase_t    ph;
    int                   hdr_idx;
    logic [15:0]          hdr_w[6];
    logic [7:0]           lbl_left;
    logic [7:0]           name_len;
    int                   tail_idx;
    logic [15:0]          tc_w[2];
    dnsqp_pkg::status_t   err_st;

    dns_query_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function void clear_parse();
        ph       = dnsqp_pkg::PH_HEADER;
        hdr_idx  = 0;
        lbl_left = '0;
        name_len = '0;
        tail_idx = 0;
        err_st   = dnsqp_pkg::ST_OK;
        for (int i = 0; i < 6; i++) hdr_w[i] = '0;
        tc_w[0] = '0;
        tc_w[1] = '0;
    endfunction

    // big-endian: even byte position fills the high half
    function automatic logic [15:0] with_byte(logic [15:0] w, int pos, logic [7:0] b);
        if (pos % 2 == 0) return {b, w[7:0]};
        return {w[15:8], b};
    endfunction

    function void push_char(logic [7:0] c);
        dnsqp_pkg::result_t r;
        r           = '0;
        r.kind      = dnsqp_pkg::KIND_CHAR;
        r.name_char = c;
        parsed_records.push_back(r);
    endfunction

    function void parse_byte(logic [7:0] b, logic last);
        dnsqp_pkg::status_t st;
        dnsqp_pkg::result_t r;
        st = dnsqp_pkg::ST_OK;
        case (ph)
            dnsqp_pkg::PH_HEADER: begin
                if (hdr_idx < dnsqp_pkg::HDR_BYTES) begin
                    hdr_w[hdr_idx / 2] = with_byte(hdr_w[hdr_idx / 2], hdr_idx, b);
                    hdr_idx++;
                end
                if (hdr_idx >= dnsqp_pkg::HDR_BYTES) begin
                    if (hdr_w[2] == 16'h0000) begin
                        err_st = dnsqp_pkg::ST_NO_QUESTION;
                        ph     = dnsqp_pkg::PH_DISCARD;
                    end else begin
                        ph = dnsqp_pkg::PH_LEN;
                    end
                end
                if (hdr_idx < dnsqp_pkg::HDR_BYTES) st = dnsqp_pkg::ST_SHORT_HDR;
                else if (err_st != dnsqp_pkg::ST_OK) st = err_st;
                else st = dnsqp_pkg::ST_NO_TYPE;
            end
            dnsqp_pkg::PH_LEN: begin
                if (b == 8'h00) begin
                    ph = dnsqp_pkg::PH_TAIL;
                    st = dnsqp_pkg::ST_NO_TYPE;
                end else if (last) begin
                    st = dnsqp_pkg::ST_LBL_OVERRUN;
                end else begin
                    if (name_len > 0 && name_len < dnsqp_pkg::MAX_NAME_CHARS) begin
                        push_char(dnsqp_pkg::DOT_CHAR);
                        name_len++;
                    end
                    lbl_left = b;
                    ph       = dnsqp_pkg::PH_BODY;
                end
            end
            dnsqp_pkg::PH_BODY: begin
                if (name_len < dnsqp_pkg::MAX_NAME_CHARS) begin
                    push_char(b);
                    name_len++;
                end
                if (lbl_left > 0) lbl_left--;
                if (lbl_left == 0) ph = dnsqp_pkg::PH_LEN;
                st = (lbl_left != 0) ? dnsqp_pkg::ST_LBL_OVERRUN : dnsqp_pkg::ST_NO_TYPE;
            end
            dnsqp_pkg::PH_TAIL: begin
                if (tail_idx < dnsqp_pkg::TAIL_BYTES) begin
                    tc_w[tail_idx / 2] = with_byte(tc_w[tail_idx / 2], tail_idx, b);
                    tail_idx++;
                end
                if (tail_idx >= dnsqp_pkg::TAIL_BYTES) ph = dnsqp_pkg::PH_DISCARD;
                st = (tail_idx < dnsqp_pkg::TAIL_BYTES) ? dnsqp_pkg::ST_NO_TYPE
                                                        : dnsqp_pkg::ST_OK;
            end
            default: st = err_st;
        endcase
        if (last) begin
            r                  = '0;
            r.kind             = dnsqp_pkg::KIND_SUMMARY;
            r.txn_id           = hdr_w[0];
            r.hdr_flags        = hdr_w[1];
            r.question_count   = hdr_w[2];
            r.answer_count     = hdr_w[3];
            r.authority_count  = hdr_w[4];
            r.additional_count = hdr_w[5];
            r.query_type       = tc_w[0];
            r.query_class      = tc_w[1];
            r.name_length      = name_len;
            r.status           = st;
            parsed_records.push_back(r);
            clear_parse();
        end
    endfunction

    // sender and receiver swap idle rates by thirds, the last third runs flat out
    function automatic int idle_pct(bit sender);
        if (n_taken < n_items / 3) return sender ? 15 : 54;
        if (n_taken < 2 * n_items / 3) return sender ? 54 : 15;
        return 0;
    endfunction

    task push_packet(int keep);
        wire_byte_t w;
        for (int i = 0; i < keep; i++) begin
            w.data = pkt_bytes[i];
            w.last = (i == keep - 1);
            byte_stream.push_back(w);
        end
    endtask

    task check_field(string fname, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected %h actual %h", $time, fname, want, got);
        end
    endtask

    always @(posedge aclk) begin
        wire_byte_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                parse_byte(s_tdata, s_tlast);
                n_taken++;
            end
            if (byte_stream.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                w = byte_stream.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= w.data;
                s_tlast  <= w.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        dnsqp_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct(1'b0));
            if (m_tvalid && m_tready) begin
                if (parsed_records.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result expected none actual tuser %h tdata %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = parsed_records.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_tuser[0]));
                    check_field("name_char", 16'(want.name_char), 16'(m_tdata[7:0]));
                    check_field("txn_id", want.txn_id, m_tdata[23:8]);
                    check_field("hdr_flags", want.hdr_flags, m_tdata[39:24]);
                    check_field("question_count", want.question_count, m_tdata[55:40]);
                    check_field("answer_count", want.answer_count, m_tdata[71:56]);
                    check_field("authority_count", want.authority_count, m_tdata[87:72]);
                    check_field("additional_count", want.additional_count,
                                m_tdata[103:88]);
                    check_field("query_type", want.query_type, m_tdata[119:104]);
                    check_field("query_class", want.query_class, m_tdata[135:120]);
                    check_field("name_length", 16'(want.name_length),
                                16'(m_tdata[143:136]));
                    check_field("status", 16'(want.status), 16'(m_tdata[146:144]));
                    check_field("pad", 16'h0000, 16'(m_tdata[151:147]));
                end
            end
        end
    end

    initial begin
        int          n_lbl;
        int          len;
        int          keep;
        logic [15:0] qd;
        clear_parse();

        // one byte only: short header
        pkt_bytes = '{8'hff};
        push_packet(1);
        // full header of ones but no questions
        pkt_bytes.delete();
        repeat (12) pkt_bytes.push_back(8'hff);
        pkt_bytes[4] = 8'h00;
        pkt_bytes[5] = 8'h00;
        push_packet(12);
        // one question, packet stops right after the header
        pkt_bytes.delete();
        repeat (12) pkt_bytes.push_back(8'h00);
        pkt_bytes[5] = 8'h01;
        push_packet(12);

        while (byte_stream.size() < 1900) begin
            pkt_bytes.delete();
            if ($urandom_range(7) == 0) begin
                // noise
                repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom_range(255)));
                push_packet(pkt_bytes.size());
            end else begin
                case ($urandom_range(9))
                    0:       qd = 16'h0000;
                    7, 8, 9: qd = 16'($urandom_range(1, 65535));
                    default: qd = 16'h0001;
                endcase
                repeat (12) pkt_bytes.push_back(8'($urandom_range(255)));
                pkt_bytes[4] = qd[15:8];
                pkt_bytes[5] = qd[7:0];
                // rarely a name long enough to hit the character limit
                if ($urandom_range(24) == 0) begin
                    n_lbl = $urandom_range(1) ? 5 : 1;
                end else begin
                    n_lbl = $urandom_range(4);
                end
                for (int l = 0; l < n_lbl; l++) begin
                    if (n_lbl == 5) len = $urandom_range(40, 63);
                    else if (n_lbl == 1 && $urandom_range(24) == 0) len = $urandom_range(192, 255);
                    else len = $urandom_range(1, 12);
                    pkt_bytes.push_back(8'(len));
                    repeat (len) begin
                        if ($urandom_range(2) == 0)
                            pkt_bytes.push_back(8'($urandom_range(255)));
                        else
                            pkt_bytes.push_back(8'($urandom_range(8'h61, 8'h7a)));
                    end
                end
                pkt_bytes.push_back(8'h00);
                repeat (4 + $urandom_range(3)) pkt_bytes.push_back(8'($urandom_range(255)));
                keep = pkt_bytes.size();
                if ($urandom_range(3) == 0) keep = $urandom_range(1, keep);
                push_packet(keep);
            end
        end
        n_items = byte_stream.size();

        do @(negedge aclk);
        while (byte_stream.size() != 0 || s_tvalid || parsed_records.size() != 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
